// ===== design/alle_pkg.sv =====
// shared constants, codes and helpers for the array linked list engine
package alle_pkg;

    localparam int CAPACITY = 64;
    localparam int SLOT_W   = 7;   // slot code incl. null code
    localparam int ADDR_W   = $clog2(CAPACITY);   // memory address
    localparam int VALUE_W  = 32;

    localparam logic [SLOT_W-1:0] NULL_CODE  = 7'd64;
    localparam logic [SLOT_W-1:0] FULL_COUNT = SLOT_W'(CAPACITY);

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_INSERT = 2'd2,
        CMD_DUMP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2,
        ST_NODEL  = 2'd3
    } t_status;

    // a slot is a live node number when it was handed out already
    function automatic logic is_node(input logic [SLOT_W-1:0] slot,
                                     input logic [SLOT_W-1:0] used);
        return slot < used;
    endfunction

endpackage

// ===== design/alle_ifs.sv =====
// command and result channel interfaces
interface alle_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      command;
    logic [alle_pkg::SLOT_W-1:0]     position;
    logic signed [alle_pkg::VALUE_W-1:0] value;

    modport source(output valid, command, position, value, input ready);
    modport sink(input valid, command, position, value, output ready);
endinterface

interface alle_res_if;
    logic                            valid;
    logic                            ready;
    logic signed [alle_pkg::VALUE_W-1:0] element;
    logic                            is_element;
    logic [1:0]                      status;
    logic                            last;

    modport source(output valid, element, is_element, status, last, input ready);
    modport sink(input valid, element, is_element, status, last, output ready);
endinterface

// ===== design/array_linked_list_engine.sv =====
// array linked list engine top level
//
// usage
// - i_cmd carries one command per transfer: push at head, delete the head or
//   the node after a node, insert after a node, or dump the list
// - o_res carries results: one status result for push, delete and insert,
//   one result per element for dump (last marks the final one), or a single
//   no-element result when a dump finds the list empty
// - one command is worked on at a time; i_cmd is ready again as soon as the
//   previous command has handed its last result to the output register
// - from transfer to result: every command passes S_DECODE and ends in S_EMIT or
//   S_DUMP; delete visits S_DEL_HEAD at the head, else S_DEL_A and then S_DEL_V
//   when a node follows the anchor, insert visits S_INS and S_INS2, and dump gives
//   one element per cycle while the receiver takes each result, all set by the
//   single registered read port of the link and value memories
// - a stalled receiver holds the output register; the engine waits and a
//   dump keeps re-reading its current node until the result is taken
// - reset empties the list (head null, no slots used); the memories are not
//   cleared, only slots already handed out are ever read
module array_linked_list_engine (
    input  logic           i_clk,
    input  logic           i_rst_n,
    alle_cmd_if.sink       i_cmd,
    alle_res_if.source     o_res
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_DECODE   = 9'b000000010,
        S_DEL_HEAD = 9'b000000100,
        S_DEL_A    = 9'b000001000,
        S_DEL_V    = 9'b000010000,
        S_INS      = 9'b000100000,
        S_INS2     = 9'b001000000,
        S_EMIT     = 9'b010000000,
        S_DUMP     = 9'b100000000
    } t_state;

    // storage: values and next links, one read and one write port each
    logic [alle_pkg::VALUE_W-1:0] r_val_mem  [alle_pkg::CAPACITY];
    logic [alle_pkg::SLOT_W-1:0]  r_link_mem [alle_pkg::CAPACITY];
    logic [alle_pkg::VALUE_W-1:0] r_val_q;
    logic [alle_pkg::SLOT_W-1:0]  r_link_q;

    // control state
    t_state                      r_state, n_state;
    alle_pkg::t_cmd              r_cmd, n_cmd;
    logic [alle_pkg::SLOT_W-1:0] r_pos, n_pos;
    logic [alle_pkg::VALUE_W-1:0] r_val, n_val;
    logic [alle_pkg::SLOT_W-1:0] r_head, n_head;
    logic [alle_pkg::SLOT_W-1:0] r_used, n_used;
    logic [alle_pkg::ADDR_W-1:0] r_anchor, n_anchor;
    logic [alle_pkg::ADDR_W-1:0] r_cur, n_cur;
    logic [alle_pkg::SLOT_W-1:0] r_n, n_n;
    alle_pkg::t_status           r_status, n_status;

    // output register
    logic                         r_out_valid, n_out_valid;
    logic [alle_pkg::VALUE_W-1:0] r_out_element, n_out_element;
    logic                         r_out_is_element, n_out_is_element;
    alle_pkg::t_status            r_out_status, n_out_status;
    logic                         r_out_last, n_out_last;

    // memory port controls
    logic [alle_pkg::ADDR_W-1:0]  rd_addr;
    logic                         link_we, val_we;
    logic [alle_pkg::ADDR_W-1:0]  link_waddr, val_waddr;
    logic [alle_pkg::SLOT_W-1:0]  link_wdata;

    logic                         out_free;
    logic [alle_pkg::SLOT_W-1:0]  anchor_slot;
    logic                         dump_fin;

    assign out_free    = !r_out_valid || o_res.ready;
    assign anchor_slot = r_pos - 7'd1;
    // final element when the link ends the list or the walk bound is reached
    assign dump_fin    = !alle_pkg::is_node(r_link_q, r_used)
                         || (r_n == 7'(alle_pkg::CAPACITY - 1));

    assign i_cmd.ready      = (r_state == S_IDLE);
    assign o_res.valid      = r_out_valid;
    assign o_res.element    = r_out_element;
    assign o_res.is_element = r_out_is_element;
    assign o_res.status     = r_out_status;
    assign o_res.last       = r_out_last;

    always_comb begin
        n_state          = r_state;
        n_cmd            = r_cmd;
        n_pos            = r_pos;
        n_val            = r_val;
        n_head           = r_head;
        n_used           = r_used;
        n_anchor         = r_anchor;
        n_cur            = r_cur;
        n_n              = r_n;
        n_status         = r_status;
        n_out_valid      = r_out_valid && !o_res.ready;
        n_out_element    = r_out_element;
        n_out_is_element = r_out_is_element;
        n_out_status     = r_out_status;
        n_out_last       = r_out_last;
        rd_addr          = r_cur;
        link_we          = 1'b0;
        val_we           = 1'b0;
        link_waddr       = r_used[alle_pkg::ADDR_W-1:0];
        val_waddr        = r_used[alle_pkg::ADDR_W-1:0];
        link_wdata       = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_cmd   = alle_pkg::t_cmd'(i_cmd.command);
                    n_pos   = i_cmd.position;
                    n_val   = i_cmd.value;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_EMIT;
                unique case (r_cmd)
                    alle_pkg::CMD_PUSH: begin
                        if (r_used == alle_pkg::FULL_COUNT) begin
                            n_status = alle_pkg::ST_FULL;
                        end else begin
                            // new node links to the old head
                            val_we     = 1'b1;
                            link_we    = 1'b1;
                            link_wdata = r_head;
                            n_head     = r_used;
                            n_used     = r_used + 7'd1;
                            n_status   = alle_pkg::ST_OK;
                        end
                    end
                    alle_pkg::CMD_DELETE: begin
                        if (r_pos == '0) begin
                            if (!alle_pkg::is_node(r_head, r_used)) begin
                                n_status = alle_pkg::ST_NODEL;
                            end else begin
                                rd_addr = r_head[alle_pkg::ADDR_W-1:0];
                                n_state = S_DEL_HEAD;
                            end
                        end else if (!alle_pkg::is_node(anchor_slot, r_used)) begin
                            n_status = alle_pkg::ST_BADPOS;
                        end else begin
                            rd_addr  = anchor_slot[alle_pkg::ADDR_W-1:0];
                            n_anchor = anchor_slot[alle_pkg::ADDR_W-1:0];
                            n_state  = S_DEL_A;
                        end
                    end
                    alle_pkg::CMD_INSERT: begin
                        // position is checked before the pool
                        if (r_pos == '0 || !alle_pkg::is_node(anchor_slot, r_used)) begin
                            n_status = alle_pkg::ST_BADPOS;
                        end else if (r_used == alle_pkg::FULL_COUNT) begin
                            n_status = alle_pkg::ST_FULL;
                        end else begin
                            rd_addr  = anchor_slot[alle_pkg::ADDR_W-1:0];
                            n_anchor = anchor_slot[alle_pkg::ADDR_W-1:0];
                            n_state  = S_INS;
                        end
                    end
                    alle_pkg::CMD_DUMP: begin
                        if (!alle_pkg::is_node(r_head, r_used)) begin
                            // empty list: one no-element result
                            n_status = alle_pkg::ST_OK;
                        end else begin
                            rd_addr = r_head[alle_pkg::ADDR_W-1:0];
                            n_cur   = r_head[alle_pkg::ADDR_W-1:0];
                            n_n     = '0;
                            n_state = S_DUMP;
                        end
                    end
                    default: n_state = S_EMIT;
                endcase
            end
            S_DEL_HEAD: begin
                n_head   = r_link_q;
                n_status = alle_pkg::ST_OK;
                n_state  = S_EMIT;
            end
            S_DEL_A: begin
                // r_link_q is the victim
                if (!alle_pkg::is_node(r_link_q, r_used)) begin
                    n_status = alle_pkg::ST_NODEL;
                    n_state  = S_EMIT;
                end else begin
                    rd_addr = r_link_q[alle_pkg::ADDR_W-1:0];
                    n_state = S_DEL_V;
                end
            end
            S_DEL_V: begin
                // anchor skips the victim
                link_we    = 1'b1;
                link_waddr = r_anchor;
                link_wdata = r_link_q;
                n_status   = alle_pkg::ST_OK;
                n_state    = S_EMIT;
            end
            S_INS: begin
                // new node takes over the anchor's link
                val_we     = 1'b1;
                link_we    = 1'b1;
                link_wdata = r_link_q;
                n_state    = S_INS2;
            end
            S_INS2: begin
                link_we    = 1'b1;
                link_waddr = r_anchor;
                link_wdata = r_used;
                n_used     = r_used + 7'd1;
                n_status   = alle_pkg::ST_OK;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out_element    = '0;
                    n_out_is_element = 1'b0;
                    n_out_status     = r_status;
                    n_out_last       = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out_element    = r_val_q;
                    n_out_is_element = 1'b1;
                    n_out_status     = alle_pkg::ST_OK;
                    n_out_last       = dump_fin;
                    if (dump_fin) begin
                        n_state = S_IDLE;
                    end else begin
                        // step to the next node
                        rd_addr = r_link_q[alle_pkg::ADDR_W-1:0];
                        n_cur   = r_link_q[alle_pkg::ADDR_W-1:0];
                        n_n     = r_n + 7'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memories: registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (val_we) begin
            r_val_mem[val_waddr] <= n_val;
        end
        if (link_we) begin
            r_link_mem[link_waddr] <= link_wdata;
        end
        r_val_q  <= r_val_mem[rd_addr];
        r_link_q <= r_link_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= alle_pkg::NULL_CODE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd            <= n_cmd;
        r_pos            <= n_pos;
        r_val            <= n_val;
        r_anchor         <= n_anchor;
        r_cur            <= n_cur;
        r_n              <= n_n;
        r_status         <= n_status;
        r_out_element    <= n_out_element;
        r_out_is_element <= n_out_is_element;
        r_out_status     <= n_out_status;
        r_out_last       <= n_out_last;
    end

    // pool never overruns
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= alle_pkg::FULL_COUNT)
        else $error("used count beyond capacity");

    // head is null or a handed-out slot
    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head == alle_pkg::NULL_CODE || r_head < r_used)
        else $error("head points at an unused slot");

    // slots are handed out one at a time
    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_used == $past(r_used) || r_used == $past(r_used) + 7'd1))
        else $error("used count jumped");

    // a command transfer starts decoding next cycle
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.valid && i_cmd.ready |=> r_state == S_DECODE)
        else $error("accepted command not decoded");

    // status results are always the final result of their command
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_is_element |-> r_out_last)
        else $error("status result without last");

endmodule
